/* hw/rtl/fms_pkg.sv */
// ----------------------------------------------------------------------------
// fms_pkg
// shared types, codes and arithmetic helpers of the flight mode sequencer
// ----------------------------------------------------------------------------
package fms_pkg;

    localparam int ALT_MAX   = 100;
    localparam int FULL_TURN = 360;
    localparam int HALF_TURN = 180;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_TAKEOFF = 2'd1;
    localparam logic [1:0] MODE_FLYING  = 2'd2;
    localparam logic [1:0] MODE_LANDING = 2'd3;

    localparam logic [1:0] SLIDE_NONE     = 2'd0;
    localparam logic [1:0] SLIDE_PUSHED   = 2'd1;
    localparam logic [1:0] SLIDE_RELEASED = 2'd2;

    localparam logic [2:0] REG_TAKEOFF_ALT     = 3'd0;
    localparam logic [2:0] REG_LANDING_FLOOR   = 3'd1;
    localparam logic [2:0] REG_ALT_TOL         = 3'd2;
    localparam logic [2:0] REG_TAKEOFF_YAW_TOL = 3'd3;
    localparam logic [2:0] REG_LANDING_YAW_TOL = 3'd4;
    localparam logic [2:0] REG_SEARCH_YAW_STEP = 3'd5;
    localparam logic [2:0] REG_USER_ALT_STEP   = 3'd6;
    localparam logic [2:0] REG_DESCENT_STEP    = 3'd7;

    typedef struct packed {
        logic [6:0] takeoff_altitude;
        logic [6:0] landing_floor_altitude;
        logic [6:0] altitude_tolerance;
        logic [7:0] takeoff_yaw_tolerance;
        logic [7:0] landing_yaw_tolerance;
        logic [8:0] search_yaw_step;
        logic [6:0] user_altitude_step;
        logic [6:0] descent_step;
    } cfg_t;

    typedef struct packed {
        logic signed [9:0] current_altitude;
        logic [8:0]        current_heading;
        logic [1:0]        slide_event;
        logic              up_pressed;
        logic              down_pressed;
        logic              right_pressed;
        logic              left_pressed;
        logic              heading_calibrated;
    } poll_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       just_entered;
        logic [6:0] goal_altitude;
        logic [8:0] goal_heading;
        logic [7:0] heading_count;
        logic [7:0] altitude_count;
        logic       flight_active;
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] target_altitude;
        logic [8:0] target_heading;
        logic       motors_enabled;
        logic       reset_controllers;
        logic       calibrate_altimeter;
        logic       stop_heading_reference;
    } result_t;

    // |a - b| with the difference wrapped into -179..180
    function automatic logic [7:0] heading_err(input logic [8:0] a, input logic [8:0] b);
        logic signed [10:0] d;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        if (d < 0) begin
            d = d + 11'sd360;
        end
        if (d < 0) begin
            d = d + 11'sd360;
        end
        if (d > 11'(HALF_TURN)) begin
            d = d - 11'sd360;
        end
        if (d < 0) begin
            d = -d;
        end
        return d[7:0];
    endfunction

    // (a + b) mod 360 for a below 360 and b at most 360
    function automatic logic [8:0] heading_add(input logic [8:0] a, input logic [8:0] b);
        logic [9:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 10'(FULL_TURN)) begin
            s = s - 10'(FULL_TURN);
        end
        return s[8:0];
    endfunction

    function automatic logic [6:0] clamp_alt(input logic signed [9:0] v);
        logic [6:0] r;
        if (v > 10'sd100) begin
            r = 7'(ALT_MAX);
        end else if (v < 0) begin
            r = 7'd0;
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

    function automatic logic [10:0] alt_err(input logic [6:0] goal,
                                            input logic signed [9:0] alt);
        logic signed [10:0] d;
        d = $signed({4'b0000, goal}) - $signed({alt[9], alt});
        if (d < 0) begin
            d = -d;
        end
        return d;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

endpackage

/* hw/rtl/fms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fms_cfg_regs
// configuration register file, written over its own valid/ready channel
// ----------------------------------------------------------------------------
module fms_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [8:0]    cfg_data,
    output fms_pkg::cfg_t cfg
);

    fms_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.takeoff_altitude       <= 7'd10;
            cfg_reg.landing_floor_altitude <= 7'd5;
            cfg_reg.altitude_tolerance     <= 7'd5;
            cfg_reg.takeoff_yaw_tolerance  <= 8'd5;
            cfg_reg.landing_yaw_tolerance  <= 8'd5;
            cfg_reg.search_yaw_step        <= 9'd15;
            cfg_reg.user_altitude_step     <= 7'd10;
            cfg_reg.descent_step           <= 7'd5;
        end else if (cfg_valid) begin
            case (cfg_index)
                fms_pkg::REG_TAKEOFF_ALT:     cfg_reg.takeoff_altitude       <= cfg_data[6:0];
                fms_pkg::REG_LANDING_FLOOR:   cfg_reg.landing_floor_altitude <= cfg_data[6:0];
                fms_pkg::REG_ALT_TOL:         cfg_reg.altitude_tolerance     <= cfg_data[6:0];
                fms_pkg::REG_TAKEOFF_YAW_TOL: cfg_reg.takeoff_yaw_tolerance  <= cfg_data[7:0];
                fms_pkg::REG_LANDING_YAW_TOL: cfg_reg.landing_yaw_tolerance  <= cfg_data[7:0];
                fms_pkg::REG_SEARCH_YAW_STEP: cfg_reg.search_yaw_step        <= cfg_data;
                fms_pkg::REG_USER_ALT_STEP:   cfg_reg.user_altitude_step     <= cfg_data[6:0];
                fms_pkg::REG_DESCENT_STEP:    cfg_reg.descent_step           <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/fms_poll_logic.sv */
// ----------------------------------------------------------------------------
// fms_poll_logic
// single-pass step logic: one poll and the current state give the next state
// and the result of the poll
// ----------------------------------------------------------------------------
module fms_poll_logic #(
    parameter int HEADING_SETTLE_POLLS  = 10,
    parameter int ALTITUDE_SETTLE_POLLS = 10,
    parameter int USER_HEADING_STEP     = 15
) (
    input  fms_pkg::state_t  st,
    input  fms_pkg::poll_t   poll,
    input  fms_pkg::cfg_t    cfg,
    output fms_pkg::state_t  st_next,
    output fms_pkg::result_t res
);

    localparam logic [7:0] HEADING_LIMIT  = 8'(HEADING_SETTLE_POLLS);
    localparam logic [7:0] ALTITUDE_LIMIT = 8'(ALTITUDE_SETTLE_POLLS);
    localparam int         USTEP_INT      = USER_HEADING_STEP % fms_pkg::FULL_TURN;
    localparam logic [8:0] RIGHT_STEP     = 9'(USTEP_INT);
    localparam logic [8:0] LEFT_STEP      = 9'(fms_pkg::FULL_TURN - USTEP_INT);

    logic        pushed;
    logic        released;
    logic [8:0]  search_step;
    logic [7:0]  herr_goal;
    logic [7:0]  herr_zero;
    logic [9:0]  land_sum;
    logic [7:0]  cnt;
    logic        pulse_reset;
    logic        pulse_cal;
    logic        pulse_stop;
    logic [1:0]  mode_n;
    fms_pkg::state_t nxt;

    assign pushed    = (poll.slide_event == fms_pkg::SLIDE_PUSHED);
    assign released  = (poll.slide_event == fms_pkg::SLIDE_RELEASED);
    assign herr_goal = fms_pkg::heading_err(st.goal_heading, poll.current_heading);
    assign herr_zero = fms_pkg::heading_err(9'd0, poll.current_heading);
    assign land_sum  = {1'b0, st.goal_heading} + {1'b0, search_step};

    always_comb begin
        if (cfg.search_yaw_step >= 9'(fms_pkg::FULL_TURN)) begin
            search_step = cfg.search_yaw_step - 9'(fms_pkg::FULL_TURN);
        end else begin
            search_step = cfg.search_yaw_step;
        end
    end

    always_comb begin
        nxt         = st;
        mode_n      = st.mode;
        pulse_reset = 1'b0;
        pulse_cal   = 1'b0;
        pulse_stop  = 1'b0;
        cnt         = 8'd0;
        case (st.mode)
            fms_pkg::MODE_IDLE: begin
                if (st.just_entered) begin
                    nxt.flight_active = 1'b0;
                end
                if (pushed) begin
                    pulse_reset       = 1'b1;
                    nxt.goal_altitude = fms_pkg::clamp_alt({3'b000, cfg.takeoff_altitude});
                    mode_n            = fms_pkg::MODE_TAKEOFF;
                end
            end
            fms_pkg::MODE_TAKEOFF: begin
                if (st.just_entered) begin
                    pulse_cal         = 1'b1;
                    nxt.flight_active = 1'b1;
                    nxt.goal_altitude = fms_pkg::clamp_alt({3'b000, cfg.takeoff_altitude});
                    nxt.heading_count = 8'd0;
                end
                if (released) begin
                    mode_n = fms_pkg::MODE_IDLE;
                end else if (poll.heading_calibrated) begin
                    nxt.goal_heading = 9'd0;
                    pulse_stop       = 1'b1;
                    mode_n           = fms_pkg::MODE_FLYING;
                end else if (herr_goal < cfg.takeoff_yaw_tolerance &&
                             fms_pkg::alt_err(nxt.goal_altitude, poll.current_altitude)
                             < {4'b0000, cfg.altitude_tolerance}) begin
                    cnt               = fms_pkg::sat_inc(nxt.heading_count);
                    nxt.heading_count = cnt;
                    if (cnt > HEADING_LIMIT) begin
                        nxt.goal_heading = fms_pkg::heading_add(st.goal_heading, search_step);
                    end
                end else begin
                    nxt.heading_count = 8'd0;
                end
            end
            fms_pkg::MODE_FLYING: begin
                if (released) begin
                    mode_n = fms_pkg::MODE_LANDING;
                end else begin
                    if (poll.up_pressed) begin
                        nxt.goal_altitude = fms_pkg::clamp_alt(
                            $signed({2'b00, {1'b0, nxt.goal_altitude}
                                            + {1'b0, cfg.user_altitude_step}}));
                    end
                    if (poll.down_pressed) begin
                        nxt.goal_altitude = fms_pkg::clamp_alt(
                            $signed({3'b000, nxt.goal_altitude})
                            - $signed({3'b000, cfg.user_altitude_step}));
                    end
                    if (poll.right_pressed) begin
                        nxt.goal_heading = fms_pkg::heading_add(nxt.goal_heading, RIGHT_STEP);
                    end
                    if (poll.left_pressed) begin
                        nxt.goal_heading = fms_pkg::heading_add(nxt.goal_heading, LEFT_STEP);
                    end
                end
            end
            fms_pkg::MODE_LANDING: begin
                if (st.just_entered) begin
                    nxt.heading_count  = 8'd0;
                    nxt.altitude_count = 8'd0;
                end
                if (pushed) begin
                    mode_n = fms_pkg::MODE_FLYING;
                end else begin
                    if (herr_goal < cfg.landing_yaw_tolerance) begin
                        cnt               = fms_pkg::sat_inc(nxt.heading_count);
                        nxt.heading_count = cnt;
                        if (cnt > HEADING_LIMIT && st.goal_heading != 9'd0) begin
                            if (st.goal_heading < 9'(fms_pkg::HALF_TURN)) begin
                                if (st.goal_heading < search_step) begin
                                    nxt.goal_heading = 9'd0;
                                end else begin
                                    nxt.goal_heading = st.goal_heading - search_step;
                                end
                            end else if (land_sum >= 10'(fms_pkg::FULL_TURN)) begin
                                nxt.goal_heading = 9'd0;
                            end else begin
                                nxt.goal_heading = land_sum[8:0];
                            end
                        end
                    end else begin
                        nxt.heading_count = 8'd0;
                    end
                    if (herr_zero < cfg.landing_yaw_tolerance) begin
                        if (poll.current_altitude
                            <= $signed({3'b000, cfg.landing_floor_altitude})) begin
                            mode_n = fms_pkg::MODE_IDLE;
                        end else if (fms_pkg::alt_err(st.goal_altitude, poll.current_altitude)
                                     < {4'b0000, cfg.altitude_tolerance}) begin
                            nxt.altitude_count = fms_pkg::sat_inc(nxt.altitude_count);
                            if (nxt.altitude_count > ALTITUDE_LIMIT) begin
                                nxt.goal_altitude = fms_pkg::clamp_alt(
                                    $signed({3'b000, st.goal_altitude})
                                    - $signed({3'b000, cfg.descent_step}));
                            end
                        end else begin
                            nxt.altitude_count = 8'd0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        nxt.just_entered = (mode_n != st.mode);
        nxt.mode         = mode_n;
    end

    assign st_next = nxt;

    assign res.mode                   = nxt.mode;
    assign res.target_altitude        = nxt.goal_altitude;
    assign res.target_heading         = nxt.goal_heading;
    assign res.motors_enabled         = nxt.flight_active;
    assign res.reset_controllers      = pulse_reset;
    assign res.calibrate_altimeter    = pulse_cal;
    assign res.stop_heading_reference = pulse_stop;

endmodule

/* hw/rtl/flight_mode_sequencer.sv */
// ----------------------------------------------------------------------------
// flight_mode_sequencer
// four-mode flight sequencer (idle, taking off, flying, landing) driven by polls
// ----------------------------------------------------------------------------
// One poll is accepted every clock cycle while the result side does not stall.
// A poll is captured in an input register, runs through the step logic and its
// result is loaded into the output register, from which it is presented; the
// input and output registers hold items while the result side stalls. The mode,
// goal altitude, goal heading and both settle counters are updated as each poll
// passes the step logic. Configuration is written over the cfg channel, which is
// always ready, and takes effect from the next poll.
// ----------------------------------------------------------------------------
module flight_mode_sequencer #(
    parameter int HEADING_SETTLE_POLLS  = 10,
    parameter int ALTITUDE_SETTLE_POLLS = 10,
    parameter int USER_HEADING_STEP     = 15
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [8:0]        cfg_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic signed [9:0] s_current_altitude,
    input  logic [8:0]        s_current_heading,
    input  logic [1:0]        s_slide_event,
    input  logic              s_up_pressed,
    input  logic              s_down_pressed,
    input  logic              s_right_pressed,
    input  logic              s_left_pressed,
    input  logic              s_heading_calibrated,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_mode,
    output logic [6:0]        m_target_altitude,
    output logic [8:0]        m_target_heading,
    output logic              m_motors_enabled,
    output logic              m_reset_controllers,
    output logic              m_calibrate_altimeter,
    output logic              m_stop_heading_reference
);

    fms_pkg::cfg_t    cfg;
    fms_pkg::poll_t   poll_reg;
    fms_pkg::state_t  state_reg;
    fms_pkg::state_t  state_next;
    fms_pkg::result_t res_next;
    fms_pkg::result_t res_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;

    fms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fms_poll_logic #(
        .HEADING_SETTLE_POLLS  (HEADING_SETTLE_POLLS),
        .ALTITUDE_SETTLE_POLLS (ALTITUDE_SETTLE_POLLS),
        .USER_HEADING_STEP     (USER_HEADING_STEP)
    ) u_step (
        .st      (state_reg),
        .poll    (poll_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (res_next)
    );

    // poll moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            poll_reg.current_altitude   <= s_current_altitude;
            poll_reg.current_heading    <= s_current_heading;
            poll_reg.slide_event        <= s_slide_event;
            poll_reg.up_pressed         <= s_up_pressed;
            poll_reg.down_pressed       <= s_down_pressed;
            poll_reg.right_pressed      <= s_right_pressed;
            poll_reg.left_pressed       <= s_left_pressed;
            poll_reg.heading_calibrated <= s_heading_calibrated;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode           <= fms_pkg::MODE_IDLE;
            state_reg.just_entered   <= 1'b1;
            state_reg.goal_altitude  <= 7'd0;
            state_reg.goal_heading   <= 9'd0;
            state_reg.heading_count  <= 8'd0;
            state_reg.altitude_count <= 8'd0;
            state_reg.flight_active  <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid                  = out_valid_reg;
    assign m_mode                   = res_reg.mode;
    assign m_target_altitude        = res_reg.target_altitude;
    assign m_target_heading         = res_reg.target_heading;
    assign m_motors_enabled         = res_reg.motors_enabled;
    assign m_reset_controllers      = res_reg.reset_controllers;
    assign m_calibrate_altimeter    = res_reg.calibrate_altimeter;
    assign m_stop_heading_reference = res_reg.stop_heading_reference;

endmodule

/* tb/flight_mode_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// flight_mode_sequencer_tb
// self-checking bench for the four-mode flight sequencer
// ----------------------------------------------------------------------------
// Polls go in through a bursty driver fed from a queue. Each accepted poll is
// run through a behavioural copy of the sequencer, and the predicted result is
// queued. A monitor stalls the result side on its own pattern and compares each
// result field by field. The run starts with a short hand-written flight. It
// then goes through several register settings: the field minima, the field
// maxima and the range maxima, and a long hover that drives both settle counters
// into saturation, and two random settings. A planning copy of the sequencer
// steers most random polls close to the current goals. A watchdog ends the run
// if transfers stop.
// ----------------------------------------------------------------------------
module flight_mode_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fms_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int HEADING_SETTLE   = 10;
    localparam int ALTITUDE_SETTLE  = 10;
    localparam int HEADING_NUDGE    = 15;
    localparam int DRAIN_CYCLES     = 8;
    localparam int STALL_LIMIT      = 2000;
    localparam int POLL_BITS        = $bits(poll_t);
    localparam int COUNT_CEILING    = 255;

    localparam logic [1:0] SLIDE_UNUSED = 2'd3;

    localparam logic [3:0] KEYS_NONE = 4'b0000;
    localparam logic [3:0] KEY_UP    = 4'b1000;
    localparam logic [3:0] KEY_DOWN  = 4'b0100;
    localparam logic [3:0] KEY_RIGHT = 4'b0010;
    localparam logic [3:0] KEY_LEFT  = 4'b0001;
    localparam logic [3:0] KEYS_ALL  = 4'b1111;

    typedef struct {
        logic [1:0] md;
        bit         entering;
        int         goal_alt;
        int         goal_head;
        int         head_cnt;
        int         alt_cnt;
        bit         motors;
    } seq_model_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data  = '0;

    logic  s_valid = 1'b0;
    logic  s_ready;
    poll_t s_poll  = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_mode;
    logic [6:0] m_target_altitude;
    logic [8:0] m_target_heading;
    logic       m_motors_enabled;
    logic       m_reset_controllers;
    logic       m_calibrate_altimeter;
    logic       m_stop_heading_reference;

    poll_t      poll_queue[$];
    result_t    expected_q[$];
    cfg_t       sim_cfg;
    seq_model_t flight_model;
    seq_model_t plan;
    int         mismatch_count = 0;
    int         burst_left     = 0;
    int         gap_left       = 0;
    int         stall_tick     = 0;
    int         quiet_cycles   = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    flight_mode_sequencer #(
        .HEADING_SETTLE_POLLS (HEADING_SETTLE),
        .ALTITUDE_SETTLE_POLLS(ALTITUDE_SETTLE),
        .USER_HEADING_STEP    (HEADING_NUDGE)
    ) dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_current_altitude      (s_poll.current_altitude),
        .s_current_heading       (s_poll.current_heading),
        .s_slide_event           (s_poll.slide_event),
        .s_up_pressed            (s_poll.up_pressed),
        .s_down_pressed          (s_poll.down_pressed),
        .s_right_pressed         (s_poll.right_pressed),
        .s_left_pressed          (s_poll.left_pressed),
        .s_heading_calibrated    (s_poll.heading_calibrated),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_mode                  (m_mode),
        .m_target_altitude       (m_target_altitude),
        .m_target_heading        (m_target_heading),
        .m_motors_enabled        (m_motors_enabled),
        .m_reset_controllers     (m_reset_controllers),
        .m_calibrate_altimeter   (m_calibrate_altimeter),
        .m_stop_heading_reference(m_stop_heading_reference)
    );

    // signed heading difference a - b folded into -179..180
    function automatic int heading_delta(input int a, input int b);
        int d;
        d = (a - b) % FULL_TURN;
        if (d < 0) begin
            d += FULL_TURN;
        end
        if (d > HALF_TURN) begin
            d -= FULL_TURN;
        end
        return d;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clip_altitude(input int v);
        if (v > ALT_MAX) begin
            return ALT_MAX;
        end
        return (v < 0) ? 0 : v;
    endfunction

    function automatic int count_up(input int c);
        return (c < COUNT_CEILING) ? c + 1 : COUNT_CEILING;
    endfunction

    function automatic seq_model_t fresh_model();
        seq_model_t st;
        st.md        = MODE_IDLE;
        st.entering  = 1'b1;
        st.goal_alt  = 0;
        st.goal_head = 0;
        st.head_cnt  = 0;
        st.alt_cnt   = 0;
        st.motors    = 1'b0;
        return st;
    endfunction

    // one poll through the sequencer, state updated in place
    function automatic result_t step_sequencer(inout seq_model_t st, input cfg_t c,
                                               input poll_t p);
        int         alt;
        int         head;
        int         stride;
        logic [1:0] nxt;
        bit         pushed;
        bit         released;
        bit         pr;
        bit         pc;
        bit         ps;
        result_t    r;
        alt      = $signed(p.current_altitude);
        head     = int'(p.current_heading);
        pushed   = p.slide_event == SLIDE_PUSHED;
        released = p.slide_event == SLIDE_RELEASED;
        stride   = int'(c.search_yaw_step) % FULL_TURN;
        nxt      = st.md;
        pr       = 1'b0;
        pc       = 1'b0;
        ps       = 1'b0;
        case (st.md)
            MODE_IDLE: begin
                if (st.entering) begin
                    st.motors = 1'b0;
                end
                if (pushed) begin
                    pr          = 1'b1;
                    st.goal_alt = clip_altitude(int'(c.takeoff_altitude));
                    nxt         = MODE_TAKEOFF;
                end
            end
            MODE_TAKEOFF: begin
                if (st.entering) begin
                    pc          = 1'b1;
                    st.motors   = 1'b1;
                    st.goal_alt = clip_altitude(int'(c.takeoff_altitude));
                    st.head_cnt = 0;
                end
                if (released) begin
                    nxt = MODE_IDLE;
                end else if (p.heading_calibrated) begin
                    st.goal_head = 0;
                    ps           = 1'b1;
                    nxt          = MODE_FLYING;
                end else if (magnitude(heading_delta(st.goal_head, head))
                                 < int'(c.takeoff_yaw_tolerance)
                             && magnitude(st.goal_alt - alt) < int'(c.altitude_tolerance)) begin
                    st.head_cnt = count_up(st.head_cnt);
                    if (st.head_cnt > HEADING_SETTLE) begin
                        st.goal_head = (st.goal_head + stride) % FULL_TURN;
                    end
                end else begin
                    st.head_cnt = 0;
                end
            end
            MODE_FLYING: begin
                if (released) begin
                    nxt = MODE_LANDING;
                end else begin
                    if (p.up_pressed) begin
                        st.goal_alt = clip_altitude(st.goal_alt + int'(c.user_altitude_step));
                    end
                    if (p.down_pressed) begin
                        st.goal_alt = clip_altitude(st.goal_alt - int'(c.user_altitude_step));
                    end
                    if (p.right_pressed) begin
                        st.goal_head = (st.goal_head + HEADING_NUDGE % FULL_TURN) % FULL_TURN;
                    end
                    if (p.left_pressed) begin
                        st.goal_head = (st.goal_head + FULL_TURN - HEADING_NUDGE % FULL_TURN)
                                       % FULL_TURN;
                    end
                end
            end
            default: begin
                if (st.entering) begin
                    st.head_cnt = 0;
                    st.alt_cnt  = 0;
                end
                if (pushed) begin
                    nxt = MODE_FLYING;
                end else begin
                    // walk the goal heading back to north by the shorter way
                    if (magnitude(heading_delta(st.goal_head, head))
                            < int'(c.landing_yaw_tolerance)) begin
                        st.head_cnt = count_up(st.head_cnt);
                        if (st.head_cnt > HEADING_SETTLE && st.goal_head != 0) begin
                            if (heading_delta(0, st.goal_head) < 0) begin
                                st.goal_head = st.goal_head - stride;
                                if (st.goal_head < 0) begin
                                    st.goal_head = 0;
                                end
                            end else begin
                                st.goal_head = st.goal_head + stride;
                                if (st.goal_head >= FULL_TURN) begin
                                    st.goal_head = 0;
                                end
                            end
                        end
                    end else begin
                        st.head_cnt = 0;
                    end
                    // descend only while pointing north
                    if (magnitude(heading_delta(0, head)) < int'(c.landing_yaw_tolerance)) begin
                        if (alt <= int'(c.landing_floor_altitude)) begin
                            nxt = MODE_IDLE;
                        end else if (magnitude(st.goal_alt - alt)
                                         < int'(c.altitude_tolerance)) begin
                            st.alt_cnt = count_up(st.alt_cnt);
                            if (st.alt_cnt > ALTITUDE_SETTLE) begin
                                st.goal_alt = clip_altitude(st.goal_alt
                                                            - int'(c.descent_step));
                            end
                        end else begin
                            st.alt_cnt = 0;
                        end
                    end
                end
            end
        endcase
        st.entering = nxt != st.md;
        st.md       = nxt;
        r.mode                   = st.md;
        r.target_altitude        = 7'(st.goal_alt);
        r.target_heading         = 9'(st.goal_head);
        r.motors_enabled         = st.motors;
        r.reset_controllers      = pr;
        r.calibrate_altimeter    = pc;
        r.stop_heading_reference = ps;
        return r;
    endfunction

    function automatic poll_t mk_poll(input int alt, input int head, input logic [1:0] slide,
                                      input logic [3:0] keys, input bit cal);
        poll_t p;
        p.current_altitude   = 10'(alt);
        p.current_heading    = 9'(head);
        p.slide_event        = slide;
        {p.up_pressed, p.down_pressed, p.right_pressed, p.left_pressed} = keys;
        p.heading_calibrated = cal;
        return p;
    endfunction

    // next poll, mostly near the planned goals; hover mode keeps every poll settled
    function automatic poll_t plan_poll(input seq_model_t pl, input bit hover);
        poll_t p;
        int    atol;
        int    hspan;
        int    aoff;
        int    hoff;
        int    alt;
        int    head;
        int    roll;
        if (!hover && $urandom_range(0, 99) < 12) begin
            p = POLL_BITS'($urandom);
            return p;
        end
        p = mk_poll(0, 0, ($urandom_range(0, 1) == 0) ? SLIDE_NONE : SLIDE_UNUSED,
                    4'($urandom), 1'($urandom));
        atol  = int'(sim_cfg.altitude_tolerance);
        hspan = (pl.md == MODE_LANDING) ? int'(sim_cfg.landing_yaw_tolerance)
                                        : int'(sim_cfg.takeoff_yaw_tolerance);
        if (hover) begin
            hspan = (hspan > 0) ? hspan - 1 : 0;
            aoff  = (atol > 1) ? int'($urandom_range(1, atol - 1)) : 1;
        end else begin
            aoff = int'($urandom_range(0, 2 * atol)) - atol;
        end
        hoff = int'($urandom_range(0, 2 * hspan)) - hspan;
        alt  = pl.goal_alt + aoff;
        if (!hover && pl.md == MODE_LANDING && $urandom_range(0, 24) == 0) begin
            alt = int'(sim_cfg.landing_floor_altitude) + int'($urandom_range(0, 3)) - 2;
        end
        head = (pl.goal_head + hoff + 2 * FULL_TURN) % FULL_TURN;
        if (!hover && head < 152 && $urandom_range(0, 19) == 0) begin
            head += FULL_TURN;
        end
        p.current_altitude = 10'(alt);
        p.current_heading  = 9'(head);
        case (pl.md)
            MODE_IDLE: begin
                if (hover || $urandom_range(0, 2) == 0) begin
                    p.slide_event = SLIDE_PUSHED;
                end
            end
            MODE_TAKEOFF: begin
                if (hover) begin
                    p.heading_calibrated = pl.head_cnt == COUNT_CEILING;
                end else begin
                    p.heading_calibrated = $urandom_range(0, 32) == 0;
                    if ($urandom_range(0, 49) == 0) begin
                        p.slide_event = SLIDE_RELEASED;
                    end
                end
            end
            MODE_FLYING: begin
                roll = int'($urandom_range(0, 99));
                if (roll < (hover ? 25 : 8)) begin
                    p.slide_event = SLIDE_RELEASED;
                end else if (!hover && roll < 11) begin
                    p.slide_event = SLIDE_PUSHED;
                end
            end
            default: begin
                if (hover ? (pl.head_cnt == COUNT_CEILING && pl.alt_cnt == COUNT_CEILING)
                          : $urandom_range(0, 39) == 0) begin
                    p.slide_event = SLIDE_PUSHED;
                end else if (!hover && $urandom_range(0, 3) == 0) begin
                    p.slide_event = SLIDE_RELEASED;
                end
            end
        endcase
        return p;
    endfunction

    function automatic logic [8:0] pick_reg_value(input int lo, input int hi);
        return ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(lo, hi));
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_poll(input poll_t p);
        void'(step_sequencer(plan, sim_cfg, p));
        poll_queue.push_back(p);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TAKEOFF_ALT:     sim_cfg.takeoff_altitude       = data[6:0];
            REG_LANDING_FLOOR:   sim_cfg.landing_floor_altitude = data[6:0];
            REG_ALT_TOL:         sim_cfg.altitude_tolerance     = data[6:0];
            REG_TAKEOFF_YAW_TOL: sim_cfg.takeoff_yaw_tolerance  = data[7:0];
            REG_LANDING_YAW_TOL: sim_cfg.landing_yaw_tolerance  = data[7:0];
            REG_SEARCH_YAW_STEP: sim_cfg.search_yaw_step        = data;
            REG_USER_ALT_STEP:   sim_cfg.user_altitude_step     = data[6:0];
            default:             sim_cfg.descent_step           = data[6:0];
        endcase
    endtask

    task automatic program_regs(input logic [8:0] to_alt, input logic [8:0] floor_alt,
                                input logic [8:0] alt_tol, input logic [8:0] to_yaw,
                                input logic [8:0] ld_yaw, input logic [8:0] search,
                                input logic [8:0] user_step, input logic [8:0] descent);
        write_reg(REG_TAKEOFF_ALT, to_alt);
        write_reg(REG_LANDING_FLOOR, floor_alt);
        write_reg(REG_ALT_TOL, alt_tol);
        write_reg(REG_TAKEOFF_YAW_TOL, to_yaw);
        write_reg(REG_LANDING_YAW_TOL, ld_yaw);
        write_reg(REG_SEARCH_YAW_STEP, search);
        write_reg(REG_USER_ALT_STEP, user_step);
        write_reg(REG_DESCENT_STEP, descent);
    endtask

    task automatic wait_drained();
        while (poll_queue.size() != 0 || s_valid || expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // poll driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (poll_queue.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_poll  <= poll_queue.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = int'($urandom_range(1, 24));
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
                end
            end
        end
    end

    // monitor: predicts on each poll transfer, checks each result transfer
    always @(posedge aclk) begin : watch_ports
        result_t seen;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_q.push_back(step_sequencer(flight_model, sim_cfg, s_poll));
            end
            if (m_valid && m_ready) begin
                seen = {m_mode, m_target_altitude, m_target_heading, m_motors_enabled,
                        m_reset_controllers, m_calibrate_altimeter, m_stop_heading_reference};
                if (expected_q.size() == 0) begin
                    $error("result transfer with no poll outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("mode", want.mode, seen.mode);
                    check_field("target_altitude", want.target_altitude,
                                seen.target_altitude);
                    check_field("target_heading", want.target_heading, seen.target_heading);
                    check_field("motors_enabled", want.motors_enabled, seen.motors_enabled);
                    check_field("reset_controllers", want.reset_controllers,
                                seen.reset_controllers);
                    check_field("calibrate_altimeter", want.calibrate_altimeter,
                                seen.calibrate_altimeter);
                    check_field("stop_heading_reference", want.stop_heading_reference,
                                seen.stop_heading_reference);
                end
            end
            stall_tick++;
            case ((stall_tick >> 7) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom);
                2:       m_ready <= (stall_tick % 8) < 2;
                default: m_ready <= $urandom_range(0, 3) != 0;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        poll_t p;
        int    n;
        bit    landed_out;
        sim_cfg = '{takeoff_altitude: 7'd10, landing_floor_altitude: 7'd5,
                    altitude_tolerance: 7'd5, takeoff_yaw_tolerance: 8'd5,
                    landing_yaw_tolerance: 8'd5, search_yaw_step: 9'd15,
                    user_altitude_step: 7'd10, descent_step: 7'd5};
        flight_model = fresh_model();
        plan         = fresh_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-written flight on the reset settings
        queue_poll(mk_poll(-512, 511, SLIDE_NONE, KEYS_ALL, 1'b1));
        queue_poll(mk_poll(511, 0, SLIDE_UNUSED, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(0, 359, SLIDE_PUSHED, KEYS_NONE, 1'b0));
        for (int i = 0; i < 12; i++) begin
            queue_poll(mk_poll(10, (i == 11) ? 375 : 0, SLIDE_NONE, KEYS_NONE, 1'b0));
        end
        queue_poll(mk_poll(10, 0, SLIDE_NONE, KEYS_NONE, 1'b1));
        queue_poll(mk_poll(0, 0, SLIDE_NONE, KEY_UP | KEY_RIGHT, 1'b0));
        queue_poll(mk_poll(0, 0, SLIDE_NONE, KEY_DOWN | KEY_LEFT, 1'b0));
        queue_poll(mk_poll(0, 0, SLIDE_RELEASED, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(511, 0, SLIDE_NONE, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(5, 0, SLIDE_NONE, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(5, 0, SLIDE_NONE, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(0, 0, SLIDE_PUSHED, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(0, 0, SLIDE_RELEASED, KEYS_NONE, 1'b0));
        queue_poll(mk_poll(0, 0, SLIDE_NONE, KEYS_NONE, 1'b0));
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_regs(0, 0, 0, 0, 0, 1, 1, 1);
                1: program_regs(127, 127, 127, 255, 255, 511, 127, 127);
                2: program_regs(100, 100, 100, 180, 180, 359, 100, 100);
                // long hover: no descent, so both settle counters run into saturation
                3: program_regs(60, 0, 20, 30, 30, 405, 7, 128);
                default: program_regs(pick_reg_value(0, 100), pick_reg_value(0, 100),
                                      pick_reg_value(0, 100), pick_reg_value(0, 180),
                                      pick_reg_value(0, 180), pick_reg_value(1, 359),
                                      pick_reg_value(1, 100), pick_reg_value(1, 100));
            endcase
            if (phase == 3) begin
                landed_out = 1'b0;
                n          = 0;
                while (!landed_out && n < 1200) begin
                    p          = plan_poll(plan, 1'b1);
                    landed_out = plan.md == MODE_LANDING && p.slide_event == SLIDE_PUSHED;
                    queue_poll(p);
                    n++;
                end
            end else begin
                repeat ((phase < 2) ? 50 : 80) queue_poll(plan_poll(plan, 1'b0));
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
